FILE: rtl/core/blended_shape_fill_engine_defines.svh
// Assertion macros for the blended shape fill engine.
`ifndef BLENDED_SHAPE_FILL_ENGINE_DEFINES_SVH
`define BLENDED_SHAPE_FILL_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define BSFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BSFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BSFE_ASSERT(lbl, prop, msg)
`define BSFE_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/bsfe_pkg.sv
// Shared types and constants of the blended shape fill engine.
package bsfe_pkg;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_RECT   = 2'd1,
		REQ_CIRCLE = 2'd2,
		REQ_READ   = 2'd3
	} req_type_t;

	// canvas register encoding
	localparam logic CFG_CANVAS_WIDTH  = 1'b0;
	localparam logic CFG_CANVAS_HEIGHT = 1'b1;

	localparam int CANVAS_BITS = 7;
	localparam int POS_BITS    = 6;
	localparam int PIX_BITS    = 32;
	// linear pixel address of a 7-bit by 7-bit canvas
	localparam int LIN_BITS    = 14;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

FILE: rtl/core/bsfe_req_if.sv
// Command channel of the blended shape fill engine.
interface bsfe_req_if;
	logic                valid;
	logic                ready;
	bsfe_pkg::req_type_t req_type;
	logic [5:0]          pos_x;
	logic [5:0]          pos_y;
	logic [6:0]          size_w;
	logic [6:0]          size_h;
	logic [31:0]         color;

	modport source (
		output valid, req_type, pos_x, pos_y, size_w, size_h, color,
		input  ready
	);
	modport sink (
		input  valid, req_type, pos_x, pos_y, size_w, size_h, color,
		output ready
	);
endinterface

FILE: rtl/core/bsfe_rsp_if.sv
// Result channel of the blended shape fill engine.
interface bsfe_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        status;

	modport source (
		output valid, read_data, status,
		input  ready
	);
	modport sink (
		input  valid, read_data, status,
		output ready
	);
endinterface

FILE: rtl/core/bsfe_ram.sv
// Single-port RAM with registered read.
module bsfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

FILE: rtl/core/blended_shape_fill_engine.sv
// Each command runs setup, a scan of its box clipped to the canvas and a finish step.
// Read fetches one word (none outside the canvas); clear writes, rectangle blends and
// circle blends within the radius (single-port frame RAM, one channel blend unit).
// One command at a time: the next can be taken in the cycle after its result is
// loaded; a result held by the sink stalls the finish step.
// Reset clears control state and sets a 64 x 64 canvas; frame is undefined.
`include "blended_shape_fill_engine_defines.svh"

module blended_shape_fill_engine #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	bsfe_req_if.sink                           req,
	bsfe_rsp_if.source                         rsp,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [bsfe_pkg::CANVAS_BITS-1:0]   cfg_wdata
);
	import bsfe_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = (AW > LIN_BITS) ? AW : LIN_BITS;
	localparam int WCAP  = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
	localparam int HCAP  = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_MIX,
		ST_RDWAIT,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [6:0]             canvas_w_q, canvas_h_q;
	logic                   rsp_valid_q;
	logic [PIX_BITS-1:0]    rsp_data_q;
	logic                   rsp_status_q;
	logic [1:0]             mix_ch_q;

	// command payload and scan state
	req_type_t              kind_q;
	logic [PIX_BITS-1:0]    color_q;
	logic [POS_BITS-1:0]    px_q, py_q;
	logic [6:0]             sw_q;
	logic [6:0]             xs_q, xe_q, ys_q, ye_q;
	logic [6:0]             x_q, y_q;
	logic [LIN_BITS-1:0]    base_q;
	logic [LIN_BITS-1:0]    rr_q;
	logic [AW-1:0]          addr_q;
	logic [15:0]            acc_q;
	logic [PIX_BITS-1:0]    res_data_q;
	logic                   res_status_q;

	logic [6:0]             w_eff, h_eff;
	logic                   accept;

	// box of the incoming command
	logic [6:0]             box_xs, box_xe, box_ys, box_ye;
	logic [7:0]             sum_x, sum_y, end_x, end_y;
	logic [6:0]             px7, py7;
	logic                   rd_outside;

	// scan datapath
	logic [6:0]             dx, dy;
	logic [LIN_BITS-1:0]    sq_x, sq_y;
	logic [LIN_BITS:0]      dist_sq;
	logic                   in_circle;
	logic [LIN_BITS-1:0]    lin14;
	logic [LW-1:0]          lin_w;
	logic [AW-1:0]          scan_addr;
	logic [6:0]             nxt_x;
	logic                   last_x, scan_last;

	// channel blend unit
	logic [7:0]             alpha, bg_byte, fg_byte, mixed;
	logic [15:0]            prod_bg, prod_fg;
	logic [7:0]             q_bg, q_fg;

	// RAM port
	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_addr;
	logic [PIX_BITS-1:0]    ram_wdata, ram_rdata;

	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [15:0] t;
		t = v + (v >> 8) + 16'd1;
		return t[15:8];
	endfunction

	assign w_eff     = (canvas_w_q > 7'(WCAP)) ? 7'(WCAP) : canvas_w_q;
	assign h_eff     = (canvas_h_q > 7'(HCAP)) ? 7'(HCAP) : canvas_h_q;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;
	assign rsp.status    = rsp_status_q;

	always_comb begin
		px7        = {1'b0, req.pos_x};
		py7        = {1'b0, req.pos_y};
		rd_outside = !((px7 < w_eff) && (py7 < h_eff));
		sum_x      = 8'(px7) + 8'(req.size_w);
		sum_y      = 8'(py7) + 8'(req.size_h);
		end_x      = 8'(px7) + 8'(req.size_w) + 8'd1;
		end_y      = 8'(py7) + 8'(req.size_w) + 8'd1;
		box_xs     = px7;
		box_ys     = py7;
		box_xe     = 7'd0;
		box_ye     = 7'd0;
		unique case (req.req_type)
			REQ_CLEAR: begin
				box_xs = 7'd0;
				box_ys = 7'd0;
				box_xe = w_eff;
				box_ye = h_eff;
			end
			REQ_RECT: begin
				box_xe = (sum_x > {1'b0, w_eff}) ? w_eff : sum_x[6:0];
				box_ye = (sum_y > {1'b0, h_eff}) ? h_eff : sum_y[6:0];
			end
			REQ_CIRCLE: begin
				// saturate the low corner at zero
				box_xs = (px7 > req.size_w) ? px7 - req.size_w : 7'd0;
				box_ys = (py7 > req.size_w) ? py7 - req.size_w : 7'd0;
				box_xe = (end_x > {1'b0, w_eff}) ? w_eff : end_x[6:0];
				box_ye = (end_y > {1'b0, h_eff}) ? h_eff : end_y[6:0];
			end
			REQ_READ: begin
				// an empty box sends an outside read straight to the result
				box_xe = rd_outside ? px7 : px7 + 7'd1;
				box_ye = py7 + 7'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		dx        = (x_q >= {1'b0, px_q}) ? x_q - {1'b0, px_q} : {1'b0, px_q} - x_q;
		dy        = (y_q >= {1'b0, py_q}) ? y_q - {1'b0, py_q} : {1'b0, py_q} - y_q;
		sq_x      = dx * dx;
		sq_y      = dy * dy;
		dist_sq   = {1'b0, sq_x} + {1'b0, sq_y};
		in_circle = (dist_sq <= {1'b0, rr_q});
		lin14     = base_q + LIN_BITS'(x_q);
		lin_w     = LW'(lin14);
		scan_addr = lin_w[AW-1:0];
		nxt_x     = x_q + 7'd1;
		last_x    = (nxt_x == xe_q);
		scan_last = last_x && ((y_q + 7'd1) == ye_q);
	end

	always_comb begin
		alpha   = color_q[7:0];
		bg_byte = ram_rdata[31:24];
		fg_byte = color_q[31:24];
		unique case (mix_ch_q)
			2'd1: begin
				bg_byte = ram_rdata[23:16];
				fg_byte = color_q[23:16];
			end
			2'd2: begin
				bg_byte = ram_rdata[15:8];
				fg_byte = color_q[15:8];
			end
			default: ;
		endcase
		prod_bg = bg_byte * alpha;
		prod_fg = fg_byte * alpha;
		q_bg    = div255(prod_bg);
		q_fg    = div255(prod_fg);
		mixed   = bg_byte - q_bg + q_fg;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = scan_addr;
		ram_wdata = color_q;
		if (state_q == ST_SCAN) begin
			unique case (kind_q)
				REQ_CLEAR:  ram_we = 1'b1;
				REQ_RECT:   ram_re = 1'b1;
				REQ_CIRCLE: ram_re = in_circle;
				REQ_READ:   ram_re = 1'b1;
				default: ;
			endcase
		end else if (state_q == ST_MIX) begin
			ram_addr  = addr_q;
			ram_we    = (mix_ch_q == 2'd2);
			ram_wdata = {acc_q, mixed, ALPHA_OPAQUE};
		end
	end

	bsfe_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			canvas_w_q   <= 7'd64;
			canvas_h_q   <= 7'd64;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
			rsp_status_q <= 1'b0;
			mix_ch_q     <= 2'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CANVAS_WIDTH:  canvas_w_q <= cfg_wdata;
					CFG_CANVAS_HEIGHT: canvas_h_q <= cfg_wdata;
					default: ;
				endcase
			end
			// the finish step reloads the register itself
			if (rsp_valid_q && rsp.ready && (state_q != ST_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if ((xs_q >= xe_q) || (ys_q >= ye_q)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					mix_ch_q <= 2'd0;
					unique case (kind_q)
						REQ_RECT:  state_q <= ST_MIX;
						REQ_READ:  state_q <= ST_RDWAIT;
						REQ_CIRCLE: begin
							if (in_circle) begin
								state_q <= ST_MIX;
							end else if (scan_last) begin
								state_q <= ST_FIN;
							end
						end
						REQ_CLEAR: begin
							if (scan_last) begin
								state_q <= ST_FIN;
							end
						end
						default: ;
					endcase
				end
				ST_MIX: begin
					mix_ch_q <= mix_ch_q + 2'd1;
					if (mix_ch_q == 2'd2) begin
						state_q <= scan_last ? ST_FIN : ST_SCAN;
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the result register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_data_q   <= res_data_q;
						rsp_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= req.req_type;
			color_q      <= req.color;
			px_q         <= req.pos_x;
			py_q         <= req.pos_y;
			sw_q         <= req.size_w;
			xs_q         <= box_xs;
			xe_q         <= box_xe;
			ys_q         <= box_ys;
			ye_q         <= box_ye;
			res_data_q   <= '0;
			res_status_q <= (req.req_type == REQ_READ) && rd_outside;
		end
		if (state_q == ST_SETUP) begin
			x_q    <= xs_q;
			y_q    <= ys_q;
			base_q <= ys_q * w_eff;
			rr_q   <= sw_q * sw_q;
		end
		if (state_q == ST_SCAN) begin
			addr_q <= scan_addr;
		end
		if (state_q == ST_MIX) begin
			if (mix_ch_q == 2'd0) begin
				acc_q[15:8] <= mixed;
			end
			if (mix_ch_q == 2'd1) begin
				acc_q[7:0] <= mixed;
			end
		end
		if (state_q == ST_RDWAIT) begin
			res_data_q <= ram_rdata;
		end
		// advance the scan position after a pixel is done
		if (((state_q == ST_SCAN) && ((kind_q == REQ_CLEAR)
				|| ((kind_q == REQ_CIRCLE) && !in_circle)))
				|| ((state_q == ST_MIX) && (mix_ch_q == 2'd2))) begin
			if (last_x) begin
				x_q    <= xs_q;
				y_q    <= y_q + 7'd1;
				base_q <= base_q + LIN_BITS'(w_eff);
			end else begin
				x_q <= nxt_x;
			end
		end
	end

	`BSFE_ASSERT_IMP(a_scan_in_box, (state_q == ST_SCAN), ((x_q >= xs_q) && (x_q < xe_q) && (y_q >= ys_q) && (y_q < ye_q)), "scan position left its box")
	`BSFE_ASSERT_IMP(a_mix_after_read, ((state_q == ST_MIX) && (mix_ch_q == 2'd0)), ($past(state_q) == ST_SCAN), "blend started without a frame read")
	`BSFE_ASSERT_IMP(a_result_from_fin, $rose(rsp_valid_q), ($past(state_q) == ST_FIN), "result appeared outside the finish step")
	`BSFE_ASSERT_IMP(a_status_no_data, (rsp_valid_q && rsp_status_q), (rsp_data_q == '0), "rejected read carries pixel data")
endmodule
